[design/efd_pkg.sv]
package efd_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int CNT_W = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_ETX = 8'h03;
    localparam logic [7:0] BYTE_ESC = 8'h04;
    localparam logic [7:0] BYTE_ESC_STX = 8'h06;
    localparam logic [7:0] BYTE_ESC_ETX = 8'h07;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    localparam logic [7:0] CMD_50 = 8'd50;
    localparam logic [7:0] CMD_52 = 8'd52;
    localparam logic [7:0] CMD_30 = 8'd30;
    localparam logic [7:0] CMD_32 = 8'd32;
    localparam logic [7:0] CMD_34 = 8'd34;
    localparam logic [7:0] CMD_36 = 8'd36;
    localparam logic [7:0] CMD_40 = 8'd40;

    localparam logic CFG_CONTROLLER_ID = 1'b0;
    localparam logic CFG_ELEVATOR_ID = 1'b1;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_CHECKSUM = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       end_of_frame;
        status_t    frame_status;
    } rec_t;

    typedef struct packed {
        logic [1:0] count;
        rec_t       rec1;
        rec_t       rec0;
    } push_t;

endpackage

[design/escaped_frame_deframer.sv]
// A result word enters the result queue at the edge that accepts the input word causing it.
// One input word per cycle while s_ready is high; a word causes zero, one or two result words.
// The result queue holds four words and takes input while at least two slots are free.
// Reset (aresetn low, synchronous) clears the frame state, both address registers and the queue.
module escaped_frame_deframer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_payload_byte,
    output logic       m_end_of_frame,
    output logic [1:0] m_frame_status
);

    efd_pkg::push_t push;
    efd_pkg::rec_t  out_rec;
    logic           accept;

    assign accept = s_valid && s_ready;

    efd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .rx_byte   (s_rx_byte),
        .push      (push)
    );

    efd_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space     (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_rec   (out_rec)
    );

    assign m_payload_byte = out_rec.payload_byte;
    assign m_end_of_frame = out_rec.end_of_frame;
    assign m_frame_status = out_rec.frame_status;

endmodule

[design/efd_core.sv]
module efd_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [7:0]     cfg_wdata,
    input  logic           accept,
    input  logic [7:0]     rx_byte,
    output efd_pkg::push_t push
);

    logic [7:0] controller_id_reg;
    logic [7:0] elevator_id_reg;

    logic                     in_frame_reg, in_frame_next;
    logic [7:0]               d0_reg, d0_next;
    logic [7:0]               d1_reg, d1_next;
    logic [1:0]               fill_reg, fill_next;
    logic                     esc_reg, esc_next;
    logic [6:0]               sum_reg, sum_next;
    logic [efd_pkg::CNT_W-1:0] count_reg, count_next;
    logic [7:0]               hdr_reg [4];
    logic [7:0]               hdr_next [4];
    logic                     ovf_reg, ovf_next;

    logic [1:0]  cand_vld;
    logic [7:0]  cand_byte [2];
    logic        is_etx;
    logic [7:0]  body;
    logic [8:0]  raw_sum;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    logic        known;
    efd_pkg::status_t verdict;
    efd_pkg::rec_t    recs [2];
    logic [1:0]  nrec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            controller_id_reg <= '0;
            elevator_id_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                efd_pkg::CFG_CONTROLLER_ID: controller_id_reg <= cfg_wdata;
                efd_pkg::CFG_ELEVATOR_ID: elevator_id_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Check digits are ASCII of sum/10 and sum%10; sum is at most 99.
    assign tens_prod = {8'd0, sum_reg} * 15'd205;
    assign tens = tens_prod[14:11];
    assign ones = sum_reg - 7'(tens) * 7'd10;

    always_comb begin
        in_frame_next = in_frame_reg;
        d0_next = d0_reg;
        d1_next = d1_reg;
        fill_next = fill_reg;
        esc_next = esc_reg;
        sum_next = sum_reg;
        count_next = count_reg;
        hdr_next = hdr_reg;
        ovf_next = ovf_reg;
        cand_vld = '0;
        cand_byte[0] = '0;
        cand_byte[1] = '0;
        is_etx = 1'b0;
        body = d0_reg;
        raw_sum = {2'd0, sum_reg} + {1'b0, d0_reg};
        recs[0] = '0;
        recs[1] = '0;
        nrec = '0;
        known = 1'b0;
        verdict = efd_pkg::ST_ACCEPTED;

        if (accept && rx_byte == efd_pkg::BYTE_STX) begin
            d0_next = '0;
            d1_next = '0;
            fill_next = '0;
            esc_next = 1'b0;
            sum_next = '0;
            count_next = '0;
            hdr_next = '{default: '0};
            ovf_next = 1'b0;
            in_frame_next = 1'b1;
        end else if (accept && in_frame_reg) begin
            if (rx_byte == efd_pkg::BYTE_ETX) begin
                is_etx = 1'b1;
                cand_vld[0] = esc_reg;
                cand_byte[0] = efd_pkg::BYTE_ESC;
            end else if (fill_reg == 2'd2) begin
                d0_next = d1_reg;
                d1_next = rx_byte;
                if (raw_sum >= 9'd300) begin
                    sum_next = 7'(raw_sum - 9'd300);
                end else if (raw_sum >= 9'd200) begin
                    sum_next = 7'(raw_sum - 9'd200);
                end else if (raw_sum >= 9'd100) begin
                    sum_next = 7'(raw_sum - 9'd100);
                end else begin
                    sum_next = raw_sum[6:0];
                end
                if (esc_reg) begin
                    esc_next = 1'b0;
                    cand_vld[0] = 1'b1;
                    case (body)
                        efd_pkg::BYTE_ESC: cand_byte[0] = efd_pkg::BYTE_ESC;
                        efd_pkg::BYTE_ESC_STX: cand_byte[0] = efd_pkg::BYTE_STX;
                        efd_pkg::BYTE_ESC_ETX: cand_byte[0] = efd_pkg::BYTE_ETX;
                        default: begin
                            cand_byte[0] = efd_pkg::BYTE_ESC;
                            cand_vld[1] = 1'b1;
                            cand_byte[1] = body;
                        end
                    endcase
                end else if (body == efd_pkg::BYTE_ESC) begin
                    esc_next = 1'b1;
                end else begin
                    cand_vld[0] = 1'b1;
                    cand_byte[0] = body;
                end
            end else begin
                if (fill_reg == 2'd0) begin
                    d0_next = rx_byte;
                end else begin
                    d1_next = rx_byte;
                end
                fill_next = fill_reg + 2'd1;
            end
        end

        for (int i = 0; i < 2; i++) begin
            if (cand_vld[i]) begin
                if (count_next >= efd_pkg::CNT_W'(efd_pkg::MAX_PAYLOAD)) begin
                    ovf_next = 1'b1;
                end else begin
                    if (count_next < efd_pkg::CNT_W'(4)) begin
                        hdr_next[count_next[1:0]] = cand_byte[i];
                    end
                    count_next = count_next + efd_pkg::CNT_W'(1);
                    recs[nrec[0]].payload_byte = cand_byte[i];
                    recs[nrec[0]].end_of_frame = 1'b0;
                    recs[nrec[0]].frame_status = efd_pkg::ST_ACCEPTED;
                    nrec = nrec + 2'd1;
                end
            end
        end

        known = (hdr_next[3] == efd_pkg::CMD_50) || (hdr_next[3] == efd_pkg::CMD_52) ||
                (hdr_next[3] == efd_pkg::CMD_30) || (hdr_next[3] == efd_pkg::CMD_32) ||
                (hdr_next[3] == efd_pkg::CMD_34) || (hdr_next[3] == efd_pkg::CMD_36) ||
                (hdr_next[3] == efd_pkg::CMD_40);
        if (fill_reg != 2'd2) begin
            verdict = efd_pkg::ST_MISMATCH;
        end else if (d0_reg != (efd_pkg::ASCII_ZERO + {4'd0, tens}) ||
                     d1_reg != (efd_pkg::ASCII_ZERO + {1'b0, ones})) begin
            verdict = efd_pkg::ST_CHECKSUM;
        end else if (ovf_next) begin
            verdict = efd_pkg::ST_OVERFLOW;
        end else if (count_next < efd_pkg::CNT_W'(4) || !known ||
                     hdr_next[0] != controller_id_reg || hdr_next[2] != elevator_id_reg) begin
            verdict = efd_pkg::ST_MISMATCH;
        end else begin
            verdict = efd_pkg::ST_ACCEPTED;
        end

        if (is_etx) begin
            recs[nrec[0]].payload_byte = '0;
            recs[nrec[0]].end_of_frame = 1'b1;
            recs[nrec[0]].frame_status = verdict;
            nrec = nrec + 2'd1;
        end

        push.count = nrec;
        push.rec0 = recs[0];
        push.rec1 = recs[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || is_etx) begin
            in_frame_reg <= 1'b0;
            d0_reg <= '0;
            d1_reg <= '0;
            fill_reg <= '0;
            esc_reg <= 1'b0;
            sum_reg <= '0;
            count_reg <= '0;
            hdr_reg <= '{default: '0};
            ovf_reg <= 1'b0;
        end else begin
            in_frame_reg <= in_frame_next;
            d0_reg <= d0_next;
            d1_reg <= d1_next;
            fill_reg <= fill_next;
            esc_reg <= esc_next;
            sum_reg <= sum_next;
            count_reg <= count_next;
            hdr_reg <= hdr_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

[design/efd_outq.sv]
module efd_outq (
    input  logic                aclk,
    input  logic                aresetn,
    input  efd_pkg::push_t      push,
    output logic                space,
    output logic                out_valid,
    input  logic                out_ready,
    output efd_pkg::rec_t       out_rec
);

    efd_pkg::rec_t                mem_reg [efd_pkg::QUEUE_DEPTH];
    logic [efd_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [efd_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [efd_pkg::QUEUE_AW:0]   count_reg, count_next;
    logic                         pop;

    assign pop = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_rec = mem_reg[rd_ptr_reg];
    assign space = (count_reg <= (efd_pkg::QUEUE_AW + 1)'(efd_pkg::QUEUE_DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + efd_pkg::QUEUE_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + efd_pkg::QUEUE_AW'(pop);
        count_next = count_reg + (efd_pkg::QUEUE_AW + 1)'(push.count)
                     - (efd_pkg::QUEUE_AW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.rec0;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_reg + efd_pkg::QUEUE_AW'(1)] <= push.rec1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

[design/efd_checker.sv]
module efd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_payload_byte,
    input logic       m_end_of_frame,
    input logic [1:0] m_frame_status
);

    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result queue not empty after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload_byte) &&
        $stable(m_end_of_frame) && $stable(m_frame_status))
        else $error("stalled result word changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input word withdrawn before it was taken");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_end_of_frame |-> m_frame_status == efd_pkg::ST_ACCEPTED)
        else $error("payload word carries a status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_frame |-> m_payload_byte == 8'd0)
        else $error("end word carries payload");

endmodule

bind escaped_frame_deframer efd_checker u_efd_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_payload_byte (m_payload_byte),
    .m_end_of_frame (m_end_of_frame),
    .m_frame_status (m_frame_status)
);

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    typedef struct packed {
        logic [7:0]       wire_b;
        logic             chk;
        efd_pkg::status_t st;
    } dir_row_t;

    // Junk outside a frame, a restarted frame that is accepted, a short frame, and an
    // escape-heavy frame that ends with an escape pending and a bad check digit.
    localparam dir_row_t DIR_TAB [26] = '{
        '{8'hFF, 1'b0, efd_pkg::ST_ACCEPTED}, '{efd_pkg::BYTE_STX, 1'b0, efd_pkg::ST_ACCEPTED},
        '{8'h11, 1'b0, efd_pkg::ST_ACCEPTED}, '{efd_pkg::BYTE_STX, 1'b0, efd_pkg::ST_ACCEPTED},
        '{8'h00, 1'b0, efd_pkg::ST_ACCEPTED}, '{8'h01, 1'b0, efd_pkg::ST_ACCEPTED},
        '{8'h00, 1'b0, efd_pkg::ST_ACCEPTED}, '{efd_pkg::CMD_50, 1'b0, efd_pkg::ST_ACCEPTED},
        '{8'h35, 1'b0, efd_pkg::ST_ACCEPTED}, '{8'h31, 1'b0, efd_pkg::ST_ACCEPTED},
        '{efd_pkg::BYTE_ETX, 1'b1, efd_pkg::ST_ACCEPTED},
        '{efd_pkg::BYTE_STX, 1'b0, efd_pkg::ST_ACCEPTED},
        '{efd_pkg::BYTE_ETX, 1'b1, efd_pkg::ST_MISMATCH},
        '{efd_pkg::BYTE_STX, 1'b0, efd_pkg::ST_ACCEPTED},
        '{efd_pkg::BYTE_ESC, 1'b0, efd_pkg::ST_ACCEPTED},
        '{efd_pkg::BYTE_ESC, 1'b0, efd_pkg::ST_ACCEPTED},
        '{efd_pkg::BYTE_ESC, 1'b0, efd_pkg::ST_ACCEPTED},
        '{efd_pkg::BYTE_ESC_STX, 1'b0, efd_pkg::ST_ACCEPTED},
        '{efd_pkg::BYTE_ESC, 1'b0, efd_pkg::ST_ACCEPTED},
        '{efd_pkg::BYTE_ESC_ETX, 1'b0, efd_pkg::ST_ACCEPTED},
        '{efd_pkg::BYTE_ESC, 1'b0, efd_pkg::ST_ACCEPTED},
        '{8'hFF, 1'b0, efd_pkg::ST_ACCEPTED}, '{efd_pkg::BYTE_ESC, 1'b0, efd_pkg::ST_ACCEPTED},
        '{8'h39, 1'b0, efd_pkg::ST_ACCEPTED}, '{8'h33, 1'b0, efd_pkg::ST_ACCEPTED},
        '{efd_pkg::BYTE_ETX, 1'b1, efd_pkg::ST_CHECKSUM}
    };

    localparam logic [7:0] SPECIAL_BYTES [5] =
        '{efd_pkg::BYTE_STX, efd_pkg::BYTE_ETX, efd_pkg::BYTE_ESC, efd_pkg::BYTE_ESC_STX,
          efd_pkg::BYTE_ESC_ETX};
    localparam logic [7:0] KNOWN_CMDS [7] =
        '{efd_pkg::CMD_50, efd_pkg::CMD_52, efd_pkg::CMD_30, efd_pkg::CMD_32,
          efd_pkg::CMD_34, efd_pkg::CMD_36, efd_pkg::CMD_40};

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_index = efd_pkg::CFG_CONTROLLER_ID;
    logic [7:0] cfg_wdata = 8'h00;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_payload_byte;
    logic       m_end_of_frame;
    logic [1:0] m_frame_status;

    escaped_frame_deframer uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_payload_byte(m_payload_byte),
        .m_end_of_frame(m_end_of_frame),
        .m_frame_status(m_frame_status)
    );

    always #2 aclk = ~aclk;

    // Predicted frame state and address registers.
    logic       frm_open = 1'b0;
    logic [7:0] dly [2] = '{8'h00, 8'h00};
    logic [1:0] dly_cnt = 2'd0;
    logic       esc_held = 1'b0;
    logic [6:0] csum = 7'd0;
    logic [5:0] pay_cnt = 6'd0;
    logic [7:0] hdr [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
    logic       ovf = 1'b0;
    logic [7:0] id_ctrl = 8'h00;
    logic [7:0] id_elev = 8'h00;

    efd_pkg::rec_t deframed_q [$];
    int   errors = 0;
    int   fed = 0;
    int   src_idle = 0;
    int   dst_idle = 0;
    int   stall_req = 0;
    int   stall_done = 0;
    int   hold_left = 0;

    function automatic void note_mismatch(string what, efd_pkg::rec_t want,
                                          efd_pkg::rec_t got);
        errors++;
        if (errors <= 10) begin
            $display("%t %s: expected byte %02h eof %0d status %0d, got byte %02h eof %0d status %0d",
                     $realtime, what, want.payload_byte, want.end_of_frame, want.frame_status,
                     got.payload_byte, got.end_of_frame, got.frame_status);
        end
    endfunction

    function automatic void clear_frame();
        frm_open = 1'b0;
        dly[0] = 8'h00;
        dly[1] = 8'h00;
        dly_cnt = 2'd0;
        esc_held = 1'b0;
        csum = 7'd0;
        pay_cnt = 6'd0;
        for (int i = 0; i < 4; i++) hdr[i] = 8'h00;
        ovf = 1'b0;
    endfunction

    function automatic void emit_pay(logic [7:0] b);
        efd_pkg::rec_t r;
        if (pay_cnt >= efd_pkg::MAX_PAYLOAD) begin
            ovf = 1'b1;
            return;
        end
        if (pay_cnt < 4) hdr[pay_cnt[1:0]] = b;
        pay_cnt++;
        r.payload_byte = b;
        r.end_of_frame = 1'b0;
        r.frame_status = efd_pkg::ST_ACCEPTED;
        deframed_q.push_back(r);
    endfunction

    function automatic void deframe_byte(logic [7:0] b);
        logic [7:0]       body;
        logic             known;
        efd_pkg::status_t st;
        efd_pkg::rec_t    r;
        if (b == efd_pkg::BYTE_STX) begin
            clear_frame();
            frm_open = 1'b1;
        end else if (frm_open && b == efd_pkg::BYTE_ETX) begin
            if (esc_held) begin
                esc_held = 1'b0;
                emit_pay(efd_pkg::BYTE_ESC);
            end
            case (hdr[3])
                efd_pkg::CMD_50, efd_pkg::CMD_52, efd_pkg::CMD_30, efd_pkg::CMD_32,
                efd_pkg::CMD_34, efd_pkg::CMD_36, efd_pkg::CMD_40: known = 1'b1;
                default: known = 1'b0;
            endcase
            if (dly_cnt < 2)
                st = efd_pkg::ST_MISMATCH;
            else if (dly[0] != 8'(efd_pkg::ASCII_ZERO + csum / 10) ||
                     dly[1] != 8'(efd_pkg::ASCII_ZERO + csum % 10))
                st = efd_pkg::ST_CHECKSUM;
            else if (ovf)
                st = efd_pkg::ST_OVERFLOW;
            else if (pay_cnt < 4 || !known || hdr[0] != id_ctrl || hdr[2] != id_elev)
                st = efd_pkg::ST_MISMATCH;
            else
                st = efd_pkg::ST_ACCEPTED;
            r.payload_byte = 8'h00;
            r.end_of_frame = 1'b1;
            r.frame_status = st;
            deframed_q.push_back(r);
            clear_frame();
        end else if (frm_open) begin
            if (dly_cnt < 2) begin
                dly[dly_cnt[0]] = b;
                dly_cnt++;
            end else begin
                body = dly[0];
                dly[0] = dly[1];
                dly[1] = b;
                csum = 7'((int'(csum) + int'(body)) % 100);
                if (esc_held) begin
                    esc_held = 1'b0;
                    if (body == efd_pkg::BYTE_ESC) begin
                        emit_pay(efd_pkg::BYTE_ESC);
                    end else if (body == efd_pkg::BYTE_ESC_STX) begin
                        emit_pay(efd_pkg::BYTE_STX);
                    end else if (body == efd_pkg::BYTE_ESC_ETX) begin
                        emit_pay(efd_pkg::BYTE_ETX);
                    end else begin
                        emit_pay(efd_pkg::BYTE_ESC);
                        emit_pay(body);
                    end
                end else if (body == efd_pkg::BYTE_ESC) begin
                    esc_held = 1'b1;
                end else begin
                    emit_pay(body);
                end
            end
        end
    endfunction

    task automatic push_byte(logic [7:0] b);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        if (frm_open || b == efd_pkg::BYTE_STX) fed++;
        deframe_byte(b);
    endtask

    task automatic write_ids(logic [7:0] ctrl, logic [7:0] elev);
        cfg_we <= 1'b1;
        cfg_index <= efd_pkg::CFG_CONTROLLER_ID;
        cfg_wdata <= ctrl;
        @(posedge aclk);
        cfg_index <= efd_pkg::CFG_ELEVATOR_ID;
        cfg_wdata <= elev;
        @(posedge aclk);
        cfg_we <= 1'b0;
        id_ctrl = ctrl;
        id_elev = elev;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic send_frame();
        logic [7:0] pay [$];
        logic [7:0] body [$];
        logic [7:0] b;
        logic [7:0] lo;
        int         n;
        int         sum;
        int         roll;
        roll = $urandom_range(99);
        if (roll < 8) begin
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)));
        end else if (roll < 14) begin
            push_byte(efd_pkg::BYTE_STX);
            repeat ($urandom_range(0, 5)) push_byte(8'($urandom_range(4, 255)));
        end else if (roll < 20) begin
            push_byte(efd_pkg::BYTE_STX);
            repeat ($urandom_range(0, 10)) push_byte(8'($urandom_range(255)));
            push_byte(efd_pkg::BYTE_ETX);
        end
        roll = $urandom_range(99);
        if (roll < 80)
            n = $urandom_range(0, 8);
        else if (roll < 95)
            n = $urandom_range(9, efd_pkg::MAX_PAYLOAD);
        else
            n = $urandom_range(efd_pkg::MAX_PAYLOAD + 1, efd_pkg::MAX_PAYLOAD + 8);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(4) == 0)
                b = SPECIAL_BYTES[$urandom_range(4)];
            else
                b = 8'($urandom_range(255));
            pay.push_back(b);
        end
        if ($urandom_range(99) < 75) begin
            if (n > 0) pay[0] = id_ctrl;
            if (n > 2) pay[2] = id_elev;
            if (n > 3) pay[3] = KNOWN_CMDS[$urandom_range(6)];
        end
        foreach (pay[i]) begin
            if (pay[i] == efd_pkg::BYTE_STX) begin
                body.push_back(efd_pkg::BYTE_ESC);
                body.push_back(efd_pkg::BYTE_ESC_STX);
            end else if (pay[i] == efd_pkg::BYTE_ETX) begin
                body.push_back(efd_pkg::BYTE_ESC);
                body.push_back(efd_pkg::BYTE_ESC_ETX);
            end else if (pay[i] == efd_pkg::BYTE_ESC) begin
                body.push_back(efd_pkg::BYTE_ESC);
                if ($urandom_range(3) != 0) body.push_back(efd_pkg::BYTE_ESC);
            end else begin
                body.push_back(pay[i]);
            end
        end
        sum = 0;
        foreach (body[i]) sum += body[i];
        sum = sum % 100;
        lo = 8'(efd_pkg::ASCII_ZERO + sum % 10);
        if ($urandom_range(9) == 0) lo = 8'(efd_pkg::ASCII_ZERO + (sum + 1) % 10);
        push_byte(efd_pkg::BYTE_STX);
        foreach (body[i]) push_byte(body[i]);
        push_byte(8'(efd_pkg::ASCII_ZERO + sum / 10));
        push_byte(lo);
        push_byte(efd_pkg::BYTE_ETX);
    endtask

    always @(posedge aclk) begin
        efd_pkg::rec_t got;
        if (aresetn && m_valid && m_ready) begin
            got.payload_byte = m_payload_byte;
            got.end_of_frame = m_end_of_frame;
            got.frame_status = efd_pkg::status_t'(m_frame_status);
            if (deframed_q.size() == 0) begin
                note_mismatch("unexpected word", '0, got);
            end else if (got !== deframed_q[0]) begin
                note_mismatch("word differs", deframed_q.pop_front(), got);
            end else begin
                void'(deframed_q.pop_front());
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_req != stall_done) begin
            hold_left = 80;
            stall_done++;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= dst_idle);
        end
    end

    initial begin
        efd_pkg::rec_t want;
        logic [7:0] ctrl;
        logic [7:0] elev;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_ids(8'h00, 8'h00);
        src_idle = 35;
        dst_idle = 62;
        foreach (DIR_TAB[i]) begin
            push_byte(DIR_TAB[i].wire_b);
            if (DIR_TAB[i].chk) begin
                want.payload_byte = 8'h00;
                want.end_of_frame = 1'b1;
                want.frame_status = DIR_TAB[i].st;
                if (deframed_q.size() == 0 || deframed_q[$] !== want)
                    note_mismatch("directed status", want, deframed_q.size() ? deframed_q[$] : '0);
            end
        end
        for (int seg = 0; seg < 6; seg++) begin
            drain();
            case (seg)
                0: begin ctrl = 8'hFF; elev = 8'hFF; end
                1: begin ctrl = 8'h00; elev = 8'hFF; end
                3: begin ctrl = 8'hFF; elev = 8'h00; end
                5: begin ctrl = 8'h00; elev = 8'h00; end
                default: begin ctrl = 8'($urandom); elev = 8'($urandom); end
            endcase
            write_ids(ctrl, elev);
            case (seg / 2)
                0: begin src_idle = 35; dst_idle = 62; end
                1: begin src_idle = 62; dst_idle = 35; end
                default: begin src_idle = 0; dst_idle = 0; end
            endcase
            if (seg == 1 || seg == 4) stall_req++;
            fed = 0;
            while (fed < 200) send_frame();
        end
        drain();
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
